// ----- design/dws_pkg.sv -----
package dws_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [IDX_W:0]    t_idx_ext;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [DATA_W-1:0] t_data;

    localparam t_cnt     FULL_CNT = CNT_W'(DEPTH);
    localparam t_idx     LAST_IDX = IDX_W'(DEPTH - 1);
    localparam t_idx_ext DEPTH_EXT = (IDX_W + 1)'(DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SEARCH     = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN
    } t_state;

    function automatic t_idx ring_inc(input t_idx idx);
        return (idx == LAST_IDX) ? '0 : t_idx'(idx + 1'b1);
    endfunction

    function automatic t_idx ring_dec(input t_idx idx);
        return (idx == '0) ? LAST_IDX : t_idx'(idx - 1'b1);
    endfunction

    function automatic t_idx ring_add(input t_idx base, input t_idx off);
        t_idx_ext sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_EXT) begin
            sum = sum - DEPTH_EXT;
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ----- design/dws_if.sv -----
interface dws_req_if;
    logic                             valid;
    logic                             ready;
    logic [dws_pkg::CMD_W-1:0]        cmd;
    logic signed [dws_pkg::DATA_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface dws_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [dws_pkg::STAT_W-1:0] status;
    logic                       found;
    logic [dws_pkg::CNT_W-1:0]  count;

    modport source (output valid, output status, output found, output count, input ready);
    modport sink   (input valid, input status, input found, input count, output ready);
endinterface

// ----- design/dws_ram.sv -----
module dws_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- design/deque_with_search_unit.sv -----
// channel  | dir | handshake    | payload
// i_req    | in  | valid/ready  | cmd[2:0], value[31:0] signed
// o_rsp    | out | valid/ready  | status[1:0], found, count[4:0]
//
// Push and pop: the response is registered on acceptance; a push writes the store
// in the accept cycle. Search: one store read per held entry through the single
// read port, stopping at the first match; an empty queue answers at once.
// A request is taken only when idle and the response register is free or
// being drained. Reset (i_rst_n low, synchronous) empties the queue.
module deque_with_search_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dws_req_if.sink   i_req,
    dws_rsp_if.source o_rsp
);

    dws_pkg::t_state  r_state, n_state;
    dws_pkg::t_idx    r_front, n_front;
    dws_pkg::t_cnt    r_count, n_count;
    dws_pkg::t_cnt    r_issue, n_issue;
    dws_pkg::t_idx    r_scan_addr, n_scan_addr;
    logic             r_rd_pend, n_rd_pend;
    dws_pkg::t_data   r_key, n_key;
    logic             r_out_valid, n_out_valid;
    dws_pkg::t_status r_out_status, n_out_status;
    logic             r_out_found, n_out_found;
    dws_pkg::t_cnt    r_out_count, n_out_count;

    logic           out_free;
    logic           req_acc;
    logic           ram_we;
    dws_pkg::t_idx  ram_waddr;
    dws_pkg::t_data ram_wdata;
    logic           ram_re;
    dws_pkg::t_data ram_rdata;
    logic           full;
    logic           empty;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == dws_pkg::S_IDLE) && out_free;
    assign req_acc     = i_req.valid && i_req.ready;
    assign full        = (r_count >= dws_pkg::FULL_CNT);
    assign empty       = (r_count == '0);
    assign ram_wdata   = dws_pkg::t_data'(i_req.value);

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.found  = r_out_found;
    assign o_rsp.count  = r_out_count;

    dws_ram #(
        .DEPTH (dws_pkg::DEPTH),
        .WIDTH (dws_pkg::DATA_W),
        .ADDR_W(dws_pkg::IDX_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_scan_addr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dws_pkg::S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_issue     <= '0;
            r_scan_addr <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_scan_addr <= n_scan_addr;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
    end

    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_count      = r_count;
        n_issue      = r_issue;
        n_scan_addr  = r_scan_addr;
        n_rd_pend    = 1'b0;
        n_key        = r_key;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        ram_we       = 1'b0;
        ram_waddr    = r_front;
        ram_re       = 1'b0;

        unique case (r_state)
            dws_pkg::S_IDLE: begin
                if (req_acc) begin
                    n_out_valid  = 1'b1;
                    n_out_status = dws_pkg::ST_DONE;
                    n_out_found  = 1'b0;
                    unique case (dws_pkg::t_cmd'(i_req.cmd))
                        dws_pkg::CMD_PUSH_FRONT: begin
                            if (full) begin
                                n_out_status = dws_pkg::ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = dws_pkg::ring_dec(r_front);
                                n_front   = dws_pkg::ring_dec(r_front);
                                n_count   = r_count + 1'b1;
                            end
                        end
                        dws_pkg::CMD_PUSH_BACK: begin
                            if (full) begin
                                n_out_status = dws_pkg::ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = dws_pkg::ring_add(r_front,
                                                r_count[dws_pkg::IDX_W-1:0]);
                                n_count   = r_count + 1'b1;
                            end
                        end
                        dws_pkg::CMD_POP_FRONT: begin
                            if (empty) begin
                                n_out_status = dws_pkg::ST_EMPTY;
                            end else begin
                                n_front = dws_pkg::ring_inc(r_front);
                                n_count = r_count - 1'b1;
                            end
                        end
                        dws_pkg::CMD_POP_BACK: begin
                            if (empty) begin
                                n_out_status = dws_pkg::ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        dws_pkg::CMD_SEARCH: begin
                            if (!empty) begin
                                n_out_valid = 1'b0;
                                n_state     = dws_pkg::S_SCAN;
                                n_key       = dws_pkg::t_data'(i_req.value);
                                n_issue     = '0;
                                n_scan_addr = r_front;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out_count = n_count;
                end
            end
            dws_pkg::S_SCAN: begin
                ram_re = (r_issue < r_count);
                if (ram_re) begin
                    n_scan_addr = dws_pkg::ring_inc(r_scan_addr);
                    n_issue     = r_issue + 1'b1;
                    n_rd_pend   = 1'b1;
                end
                if (r_rd_pend && (ram_rdata == r_key)) begin
                    n_state      = dws_pkg::S_IDLE;
                    n_rd_pend    = 1'b0;
                    n_out_valid  = 1'b1;
                    n_out_status = dws_pkg::ST_DONE;
                    n_out_found  = 1'b1;
                    n_out_count  = r_count;
                end else if (!ram_re) begin
                    n_state      = dws_pkg::S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_status = dws_pkg::ST_DONE;
                    n_out_found  = 1'b0;
                    n_out_count  = r_count;
                end
            end
            default: begin
                n_state = dws_pkg::S_IDLE;
            end
        endcase
    end

    a_scan_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dws_pkg::S_SCAN) |-> !r_out_valid)
        else $error("response pending during search");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dws_pkg::FULL_CNT)
        else $error("entry count above depth");

    a_empty_pop_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && empty && (i_req.cmd == dws_pkg::CMD_POP_FRONT
                              || i_req.cmd == dws_pkg::CMD_POP_BACK))
        |=> ($stable(r_count) && $stable(r_front)
             && r_out_status == dws_pkg::ST_EMPTY))
        else $error("pop on empty queue changed state");

    a_search_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && i_req.cmd == dws_pkg::CMD_SEARCH)
        |=> (r_state == dws_pkg::S_SCAN || r_out_valid))
        else $error("search request lost");

    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dws_pkg::S_SCAN) |-> (!ram_we && $stable(r_count)))
        else $error("store modified during search");

endmodule
